// ===== rtl/core/dotec_pkg.sv =====
// Package: types, widths and saturating helpers for the daily on-time event counter.
`default_nettype none
package dotec_pkg;

  localparam int STAMP_BITS = 48;
  localparam int SUM_BITS   = 32;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  localparam sum_t SUM_MAX = {SUM_BITS{1'b1}};

  typedef struct packed {
    logic        level;
    logic [47:0] stamp_ms;
    logic [4:0]  day_of_month;
    logic [26:0] ms_of_day;
  } in_item_t;

  typedef struct packed {
    logic [31:0] today_events;
    logic [31:0] today_on_ms;
    logic        today_active;
    logic [31:0] yesterday_events;
    logic [31:0] yesterday_on_ms;
    logic        yesterday_active;
  } out_item_t;

  // Time from one stamp to a later one; zero when time did not move forward.
  function automatic stamp_t elapsed(stamp_t from_stamp, stamp_t to_stamp);
    return (to_stamp > from_stamp) ? (to_stamp - from_stamp) : '0;
  endfunction

  // Adds an elapsed time to a running sum and clamps at the all-ones value.
  function automatic sum_t sat_add(sum_t a, stamp_t b);
    logic [STAMP_BITS:0] s;
    s = (STAMP_BITS+1)'(a) + (STAMP_BITS+1)'(b);
    return (s > (STAMP_BITS+1)'(SUM_MAX)) ? SUM_MAX : s[SUM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/daily_on_time_event_counter.sv =====
// Each accepted input beat passes through the input register, then the result register,
// to its result beat. Throughput: one beat per cycle, limited only by output stall.
// Each input beat yields exactly one result beat carrying today's and yesterday's figures.
// Reset (synchronous, active high) clears all day counters, stamps, flags and both
// pipeline valid bits.
`default_nettype none
module daily_on_time_event_counter import dotec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // Input register.
  logic     s1_valid;
  in_item_t s1;

  // Day state.
  sum_t       cur_count, cur_time, prev_count, prev_time;
  logic       cur_on, prev_on;
  stamp_t     set_stamp, midnight_stamp;
  logic       midnight_valid;
  logic [4:0] roll_day;
  logic       roll_valid;

  sum_t       cur_count_next, cur_time_next, prev_count_next, prev_time_next;
  logic       cur_on_next, prev_on_next;
  stamp_t     set_stamp_next, midnight_stamp_next;
  logic       midnight_valid_next;
  out_item_t  out_next;

  logic s2_ready, s1_fire;

  assign s2_ready = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  stamp_t stamp, msday, mid, base_old, e_mid, e_run;
  sum_t   time_base, count_base, run_sum;
  logic   roll, roll_on;

  always_comb begin
    stamp      = STAMP_BITS'(s1.stamp_ms);
    msday      = STAMP_BITS'(s1.ms_of_day);
    roll       = roll_valid && (s1.day_of_month != roll_day);
    roll_on    = roll && cur_on;
    mid        = (msday > stamp) ? '0 : (stamp - msday);
    base_old   = midnight_valid ? midnight_stamp : set_stamp;
    e_mid      = elapsed(base_old, mid);
    // After a roll the running interval starts at midnight, so its length is the
    // time of day, clamped by the stamp itself.
    e_run      = roll_on ? ((msday > stamp) ? stamp : msday) : elapsed(base_old, stamp);
    time_base  = roll ? '0 : cur_time;
    count_base = roll ? '0 : cur_count;
    run_sum    = sat_add(time_base, e_run);

    prev_count_next     = roll ? cur_count : prev_count;
    prev_time_next      = roll ? (cur_on ? sat_add(cur_time, e_mid) : cur_time) : prev_time;
    prev_on_next        = roll ? cur_on : prev_on;
    midnight_stamp_next = roll_on ? mid : midnight_stamp;
    midnight_valid_next = roll_on ? 1'b1 : midnight_valid;
    set_stamp_next      = set_stamp;
    cur_on_next         = cur_on;
    cur_count_next      = count_base;
    cur_time_next       = time_base;

    if (s1.level && !cur_on) begin
      cur_on_next         = 1'b1;
      cur_count_next      = (count_base == SUM_MAX) ? SUM_MAX : count_base + 1'b1;
      set_stamp_next      = stamp;
      midnight_valid_next = 1'b0;
    end else if (!s1.level && cur_on) begin
      cur_on_next         = 1'b0;
      cur_time_next       = run_sum;
      midnight_valid_next = 1'b0;
    end

    out_next.today_events     = 32'(cur_count_next);
    // A beat that just set the level has no running time yet.
    out_next.today_on_ms      = 32'((cur_on_next && cur_on) ? run_sum : cur_time_next);
    out_next.today_active     = cur_on_next;
    out_next.yesterday_events = 32'(prev_count_next);
    out_next.yesterday_on_ms  = 32'(prev_time_next);
    out_next.yesterday_active = prev_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count      <= '0;
      cur_time       <= '0;
      cur_on         <= 1'b0;
      prev_count     <= '0;
      prev_time      <= '0;
      prev_on        <= 1'b0;
      set_stamp      <= '0;
      midnight_stamp <= '0;
      midnight_valid <= 1'b0;
      roll_day       <= '0;
      roll_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (s1_fire) begin
        cur_count      <= cur_count_next;
        cur_time       <= cur_time_next;
        cur_on         <= cur_on_next;
        prev_count     <= prev_count_next;
        prev_time      <= prev_time_next;
        prev_on        <= prev_on_next;
        set_stamp      <= set_stamp_next;
        midnight_stamp <= midnight_stamp_next;
        midnight_valid <= midnight_valid_next;
        roll_day       <= s1.day_of_month;
        roll_valid     <= 1'b1;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_fire) begin
      out_data <= out_next;
    end
  end

endmodule
`default_nettype wire
